[design/utf8_fullwidth_to_halfwidth_defines.svh]
// Assertion macros for the fullwidth-to-halfwidth converter.
// Included by the top level; it needs no other file.
`ifndef UTF8_FULLWIDTH_TO_HALFWIDTH_DEFINES_SVH
`define UTF8_FULLWIDTH_TO_HALFWIDTH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fw2hw_pkg.sv]
// Shared types and constants for the fullwidth-to-halfwidth converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fw2hw_pkg;

  // Byte classification.
  localparam logic [7:0] LEAD_MASK = 8'hF0;
  localparam logic [7:0] LEAD_CODE = 8'hE0;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] CONT_MASK = 8'h3F;

  // Code points and their replacements.
  localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [15:0] CP_FW_FIRST = 16'hFF01;
  localparam logic [15:0] CP_FW_LAST = 16'hFF5E;
  localparam logic [15:0] CP_FW_OFFSET = 16'hFEE0;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] ASCII_QUESTION = 8'h3F;
  localparam logic [7:0] ASCII_EXCLAIM = 8'h21;

  // Output queue sizing.
  localparam int RUN_MAX = 3;
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW = 3;
  localparam int OUTQ_LW = 4;
  localparam int OUTQ_SPACE_LIMIT = OUTQ_DEPTH - RUN_MAX;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       text_done;
  } out_item_t;

  // Result bytes produced by one input byte; items[0] goes out first.
  typedef struct packed {
    logic [1:0]                 count;
    out_item_t [RUN_MAX-1:0]    items;
  } run_t;

  typedef struct packed {
    logic [OUTQ_LW-1:0] level;
    logic               room;
  } outq_status_t;

endpackage

`default_nettype wire

[design/fw2hw_decode.sv]
// Group tracking and code point conversion for one input byte.
// Depends on fw2hw_pkg; feeds its run of result bytes to fw2hw_outq.
`timescale 1ns / 1ps
`default_nettype none

module fw2hw_decode
  import fw2hw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output run_t     run
);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] lead_byte;
  logic [7:0] lead_byte_next;
  logic [7:0] second_byte;
  logic [7:0] second_byte_next;

  always_comb begin
    phase_next       = phase;
    lead_byte_next   = lead_byte;
    second_byte_next = second_byte;
    case (phase)
      PH_IDLE: begin
        if ((item.in_byte & LEAD_MASK) == LEAD_CODE && !item.end_of_text) begin
          lead_byte_next = item.in_byte;
          phase_next     = PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (item.end_of_text) begin
          phase_next = PH_IDLE;
        end else begin
          second_byte_next = item.in_byte;
          phase_next       = PH_SECOND;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] cp;
    logic [7:0]  half;
    logic [7:0]  lead_lo;
    logic [7:0]  second_lo;
    logic [7:0]  b_lo;
    b         = item.in_byte;
    lead_lo   = lead_byte & NIBBLE_MASK;
    second_lo = second_byte & CONT_MASK;
    b_lo      = b & CONT_MASK;
    cp        = {lead_lo[3:0], second_lo[5:0], b_lo[5:0]};
    half      = 8'((cp - CP_FW_OFFSET) & 16'h00FF);
    run       = '0;
    case (phase)
      PH_IDLE: begin
        if ((b & LEAD_MASK) != LEAD_CODE || item.end_of_text) begin
          run.items[0].out_byte = b;
          run.count             = 2'd1;
        end
      end
      PH_LEAD: begin
        if (item.end_of_text) begin
          // The text ends inside the group: flush what is held.
          run.items[0].out_byte = lead_byte;
          run.items[1].out_byte = b;
          run.count             = 2'd2;
        end
      end
      default: begin
        if (cp == CP_IDEO_SPACE) begin
          run.items[0].out_byte = ASCII_SPACE;
          run.count             = 2'd1;
        end else if (cp >= CP_FW_FIRST && cp <= CP_FW_LAST &&
                     half != ASCII_COMMA && half != ASCII_QUESTION &&
                     half != ASCII_EXCLAIM) begin
          run.items[0].out_byte = half;
          run.count             = 2'd1;
        end else begin
          run.items[0].out_byte = lead_byte;
          run.items[1].out_byte = second_byte;
          run.items[2].out_byte = b;
          run.count             = 2'd3;
        end
      end
    endcase
    for (int i = 0; i < RUN_MAX; i++) begin
      if (2'(i) == run.count - 2'd1) begin
        run.items[i].last_of_run = 1'b1;
        run.items[i].text_done   = item.end_of_text;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      lead_byte   <= '0;
      second_byte <= '0;
    end else if (take) begin
      phase       <= phase_next;
      lead_byte   <= lead_byte_next;
      second_byte <= second_byte_next;
    end
  end

endmodule

`default_nettype wire

[design/fw2hw_outq.sv]
// Output byte queue: takes a run of up to three bytes per cycle, gives one.
// Depends on fw2hw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fw2hw_outq
  import fw2hw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  run_t         run,
  input  logic         pop,
  output out_item_t    head,
  output outq_status_t status
);

  out_item_t          slots [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr;
  logic [OUTQ_AW-1:0] rd_ptr;
  logic [OUTQ_LW-1:0] level;
  logic [1:0]         push_n;

  assign push_n        = push ? run.count : 2'd0;
  assign head          = slots[rd_ptr];
  assign status.level  = level;
  assign status.room   = level <= OUTQ_LW'(OUTQ_SPACE_LIMIT);

  always_ff @(posedge clk) begin
    for (int i = 0; i < RUN_MAX; i++) begin
      if (2'(i) < push_n) begin
        slots[wr_ptr + OUTQ_AW'(i)] <= run.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_AW'(push_n);
      rd_ptr <= rd_ptr + OUTQ_AW'(pop);
      level  <= level + OUTQ_LW'(push_n) - OUTQ_LW'(pop);
    end
  end

endmodule

`default_nettype wire

[design/utf8_fullwidth_to_halfwidth.sv]
// Channel  | Signals                        | Carries
// in       | in_valid, in_ready, in_item    | one text byte and its end flag
// out      | out_valid, out_ready, out_item | one converted byte and run flags
//
// An accepted byte is held in the staging register, where it is decoded and its
// run of zero to three bytes is written to an eight-entry queue once the queue
// has room; the first result byte is then offered at the queue head.
// One byte per cycle is sustained in both directions while out_ready is high; the
// staging register holds its byte while the queue has fewer than three free entries.
// Reset (rst, synchronous) empties the queue and closes any open group.
// Depends on fw2hw_pkg, fw2hw_decode, fw2hw_outq and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_fullwidth_to_halfwidth_defines.svh"

module utf8_fullwidth_to_halfwidth
  import fw2hw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic         s1_valid;
  in_item_t     s1_item;
  logic         s1_take;
  logic         pop;
  run_t         run;
  outq_status_t q_status;

  assign s1_take   = s1_valid && q_status.room;
  assign in_ready  = !s1_valid || q_status.room;
  assign out_valid = q_status.level != '0;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  fw2hw_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .take (s1_take),
    .item (s1_item),
    .run  (run)
  );

  fw2hw_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (s1_take),
    .run    (run),
    .pop    (pop),
    .head   (out_item),
    .status (q_status)
  );

  // The queue never holds more bytes than it has entries.
  `FW_ASSERT_NOW(a_level_bound, clk, rst, 1'b1, q_status.level <= OUTQ_LW'(OUTQ_DEPTH), "output queue overflow")
  // A decoded run that produces bytes makes a result available next cycle.
  `FW_ASSERT_NEXT(a_run_shows, clk, rst, s1_take && run.count != 2'd0, out_valid, "run bytes lost")
  // An end-of-text byte always yields at least one result byte.
  `FW_ASSERT_NOW(a_end_emits, clk, rst, s1_take && s1_item.end_of_text, run.count != 2'd0, "end of text produced no byte")

endmodule

`default_nettype wire
